>>> src/cnv_pkg.sv
// Shared constants, types and tap helpers for the 3x3 border-normalized convolution.
package cnv_pkg;

    localparam int MAX_WIDTH      = 2048;
    localparam int HEIGHT_LIMIT   = 4096;
    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_FRAC_BITS = 12;
    localparam int COEF_W         = 16;
    localparam int ROW_COEF_W     = 3 * COEF_W;
    localparam int PIX_W          = 3 * SAMPLE_BITS;
    localparam int ADDR_W         = $clog2(MAX_WIDTH);
    localparam int COL_W          = ADDR_W + 1;
    localparam int ROW_W          = $clog2(HEIGHT_LIMIT) + 1;
    localparam int FW_W           = 12;
    localparam int FH_W           = 13;
    localparam int PROD_W         = SAMPLE_BITS + COEF_W + 1;
    localparam int ACC_W          = PROD_W + 5;
    localparam int WSUM_W         = COEF_W + 5;
    localparam int NUM_W          = ACC_W - 1;
    localparam int DEN_W          = WSUM_W;
    localparam int TAP_W          = 4;
    localparam int TAPS           = 9;
    localparam int DIV_CNT_W      = $clog2(NUM_W);
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = ROW_COEF_W;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_TOP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_MID    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMALIZE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT= 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COLOR   = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MAC,
        S_RND,
        S_DIV,
        S_DSTORE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic             capture;
        logic             load;
        logic             mac_first;
        logic             mac_mul;
        logic             mac_add;
        logic [TAP_W-1:0] tap;
        logic [1:0]       ch;
        logic             rnd;
        logic             div_load;
        logic             div_step;
        logic             div_store;
        logic             out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic drop;
        logic emit;
        logic use_div;
        logic num_neg;
        logic last_ch;
        logic out_free;
    } t_dp_sts;

    function automatic logic [1:0] f_tap_row(input logic [TAP_W-1:0] tap);
        logic [1:0] r;
        unique case (tap)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] f_tap_col(input logic [TAP_W-1:0] tap);
        logic [1:0] c;
        unique case (tap)
            4'd0, 4'd3, 4'd6: c = 2'd0;
            4'd1, 4'd4, 4'd7: c = 2'd1;
            default:          c = 2'd2;
        endcase
        return c;
    endfunction

endpackage

>>> src/cnv_ram.sv
// Generic single-port RAM with registered read.
module cnv_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/cnv_ctrl.sv
// Sequencer: item intake, per-channel MAC sweep, divider steps and result handoff.
module cnv_ctrl
    import cnv_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state                r_state, n_state;
    logic [TAP_W-1:0]      r_tap, n_tap;
    logic [1:0]            r_ch, n_ch;
    logic [DIV_CNT_W-1:0]  r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tap   <= '0;
            r_ch    <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
            r_ch    <= n_ch;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_tap   = r_tap;
        n_ch    = r_ch;
        n_cnt   = r_cnt;
        o_ready = 1'b0;
        o_cmd   = '0;
        o_cmd.tap = r_tap;
        o_cmd.ch  = r_ch;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid && !i_sts.drop) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_tap = '0;
                n_ch  = '0;
                n_state = i_sts.emit ? S_MAC : S_IDLE;
            end
            S_MAC: begin
                o_cmd.mac_first = (r_tap == '0);
                o_cmd.mac_mul   = (r_tap < TAP_W'(TAPS));
                o_cmd.mac_add   = (r_tap != '0);
                if (r_tap == TAP_W'(TAPS)) begin
                    n_state = S_RND;
                end else begin
                    n_tap = r_tap + 1'b1;
                end
            end
            S_RND: begin
                if (i_sts.use_div && !i_sts.num_neg) begin
                    o_cmd.div_load = 1'b1;
                    n_cnt = '0;
                    n_state = S_DIV;
                end else begin
                    o_cmd.rnd = 1'b1;
                    n_tap = '0;
                    if (i_sts.last_ch) begin
                        n_state = S_OUT;
                    end else begin
                        n_ch = r_ch + 1'b1;
                        n_state = S_MAC;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(NUM_W - 1)) begin
                    n_state = S_DSTORE;
                end
            end
            S_DSTORE: begin
                o_cmd.div_store = 1'b1;
                n_tap = '0;
                if (i_sts.last_ch) begin
                    n_state = S_OUT;
                end else begin
                    n_ch = r_ch + 1'b1;
                    n_state = S_MAC;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> src/cnv_dp.sv
// Datapath: config registers, row stores, tap window, MAC, divider and output register.
module cnv_dp
    import cnv_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts,
    input  logic                   i_kind,
    input  logic [SAMPLE_BITS-1:0] i_chan_zero,
    input  logic [SAMPLE_BITS-1:0] i_chan_one,
    input  logic [SAMPLE_BITS-1:0] i_chan_two,
    input  logic                   i_ready,
    output logic                   o_valid,
    output logic [SAMPLE_BITS-1:0] o_res_zero,
    output logic [SAMPLE_BITS-1:0] o_res_one,
    output logic [SAMPLE_BITS-1:0] o_res_two,
    output logic                   o_frame_end,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    // configuration
    logic [ROW_COEF_W-1:0]  r_coef_top, r_coef_mid, r_coef_bot;
    logic                   r_normalize, r_color_mode;
    logic [FW_W-1:0]        r_frame_width;
    logic [FH_W-1:0]        r_frame_height;
    logic [SAMPLE_BITS-1:0] r_color_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_top     <= '0;
            r_coef_mid     <= ROW_COEF_W'(1) << (COEF_W + COEF_FRAC_BITS);
            r_coef_bot     <= '0;
            r_normalize    <= 1'b0;
            r_color_mode   <= 1'b0;
            r_frame_width  <= FW_W'(MAX_WIDTH);
            r_frame_height <= FH_W'(1);
            r_color_lim    <= SAMPLE_BITS'(255);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COEF_TOP:     r_coef_top     <= i_cfg_data;
                CFG_COEF_MID:     r_coef_mid     <= i_cfg_data;
                CFG_COEF_BOTTOM:  r_coef_bot     <= i_cfg_data;
                CFG_NORMALIZE:    r_normalize    <= i_cfg_data[0];
                CFG_COLOR_MODE:   r_color_mode   <= i_cfg_data[0];
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FH_W-1:0];
                CFG_MAX_COLOR:    r_color_lim    <= i_cfg_data[SAMPLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // effective geometry
    logic [COL_W-1:0] w_eff;
    logic [ROW_W-1:0] h_eff;

    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = COL_W'(1);
        end else if (COL_W'(r_frame_width) > COL_W'(MAX_WIDTH)) begin
            w_eff = COL_W'(MAX_WIDTH);
        end else begin
            w_eff = COL_W'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            h_eff = ROW_W'(1);
        end else if (ROW_W'(r_frame_height) > ROW_W'(HEIGHT_LIMIT)) begin
            h_eff = ROW_W'(HEIGHT_LIMIT);
        end else begin
            h_eff = ROW_W'(r_frame_height);
        end
    end

    // positions
    logic [COL_W-1:0] r_in_col, r_out_col;
    logic [ROW_W-1:0] r_in_row, r_out_row;
    logic             received, emit, frame_end;
    logic [COL_W-1:0] in_col_inc, out_col_inc;
    logic [ROW_W-1:0] out_row_inc;
    logic [ADDR_W-1:0] idx;

    assign received    = (r_in_row >= h_eff);
    assign emit        = ((r_in_row == ROW_W'(1)) && (r_in_col != '0))
                         || (r_in_row >= ROW_W'(2));
    assign in_col_inc  = r_in_col + 1'b1;
    assign out_col_inc = r_out_col + 1'b1;
    assign out_row_inc = r_out_row + 1'b1;
    assign frame_end   = (out_row_inc >= h_eff) && (out_col_inc >= w_eff);
    assign idx = (r_in_col >= COL_W'(MAX_WIDTH)) ? ADDR_W'(MAX_WIDTH - 1)
                                                 : r_in_col[ADDR_W-1:0];

    // sample capture, clamped to the color limit; drain requests carry zeros
    logic [PIX_W-1:0] r_samp;
    logic [PIX_W-1:0] samp_in;

    always_comb begin
        samp_in = '0;
        if (!received) begin
            samp_in[0*SAMPLE_BITS +: SAMPLE_BITS] =
                (i_chan_zero > r_color_lim) ? r_color_lim : i_chan_zero;
            samp_in[1*SAMPLE_BITS +: SAMPLE_BITS] =
                (i_chan_one > r_color_lim) ? r_color_lim : i_chan_one;
            samp_in[2*SAMPLE_BITS +: SAMPLE_BITS] =
                (i_chan_two > r_color_lim) ? r_color_lim : i_chan_two;
        end
    end

    // row stores
    logic [PIX_W-1:0] older_rd, newer_rd;
    logic             ram_en;

    assign ram_en = i_cmd.capture | i_cmd.load;

    cnv_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (i_cmd.load),
        .i_addr  (idx),
        .i_wdata (newer_rd),
        .o_rdata (older_rd)
    );

    cnv_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (i_cmd.load),
        .i_addr  (idx),
        .i_wdata (r_samp),
        .o_rdata (newer_rd)
    );

    // tap window [column][row]
    logic [PIX_W-1:0] r_win [0:2][0:2];

    // tap select
    logic [1:0]                tr, tc;
    logic [ROW_COEF_W-1:0]     coef_row;
    logic signed [COEF_W-1:0]  wt;
    logic [PIX_W-1:0]          tap_pix;
    logic [SAMPLE_BITS-1:0]    tap_s;
    logic                      ok;

    always_comb begin
        tr = f_tap_row(i_cmd.tap);
        tc = f_tap_col(i_cmd.tap);
        unique case (tr)
            2'd0:    coef_row = r_coef_top;
            2'd1:    coef_row = r_coef_mid;
            default: coef_row = r_coef_bot;
        endcase
        unique case (tc)
            2'd0:    wt = coef_row[0*COEF_W +: COEF_W];
            2'd1:    wt = coef_row[1*COEF_W +: COEF_W];
            default: wt = coef_row[2*COEF_W +: COEF_W];
        endcase
        unique case (tc)
            2'd0:    tap_pix = r_win[0][tr];
            2'd1:    tap_pix = r_win[1][tr];
            default: tap_pix = r_win[2][tr];
        endcase
        unique case (i_cmd.ch)
            2'd0:    tap_s = tap_pix[0*SAMPLE_BITS +: SAMPLE_BITS];
            2'd1:    tap_s = tap_pix[1*SAMPLE_BITS +: SAMPLE_BITS];
            default: tap_s = tap_pix[2*SAMPLE_BITS +: SAMPLE_BITS];
        endcase
        ok = 1'b1;
        if (tr == 2'd0 && r_out_row == '0)     ok = 1'b0;
        if (tr == 2'd2 && out_row_inc >= h_eff) ok = 1'b0;
        if (tc == 2'd0 && r_out_col == '0)     ok = 1'b0;
        if (tc == 2'd2 && out_col_inc >= w_eff) ok = 1'b0;
    end

    // MAC
    logic signed [PROD_W-1:0] samp_x, wt_x;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [COEF_W-1:0] r_wprod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [WSUM_W-1:0] r_wsum;

    // both operands at full product width so the multiply is signed and unclipped
    assign samp_x = PROD_W'($signed({1'b0, tap_s}));
    assign wt_x   = PROD_W'(wt);

    // rounding and normalization
    logic signed [ACC_W-1:0]               t_plain;
    logic [ACC_W-COEF_FRAC_BITS-1:0]       q_plain;
    logic [SAMPLE_BITS-1:0]                res_plain;
    logic signed [ACC_W:0]                 num;
    logic                                  use_div;

    assign t_plain = r_acc + ACC_W'(1 << (COEF_FRAC_BITS - 1));
    assign q_plain = t_plain[ACC_W-1:COEF_FRAC_BITS];
    always_comb begin
        if (t_plain[ACC_W-1]) begin
            res_plain = '0;
        end else if (q_plain > (ACC_W-COEF_FRAC_BITS)'(r_color_lim)) begin
            res_plain = r_color_lim;
        end else begin
            res_plain = q_plain[SAMPLE_BITS-1:0];
        end
    end
    assign num = {r_acc, 1'b0} + (ACC_W+1)'(r_wsum);
    assign use_div = r_normalize && !r_wsum[WSUM_W-1] && (r_wsum != '0);

    // restoring divider, one quotient bit per step
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W:0]   r_den;
    logic [DEN_W:0]   rem_sh;
    logic [SAMPLE_BITS-1:0] res_div;

    assign rem_sh = {r_rem[DEN_W-1:0], r_quo[NUM_W-1]};
    assign res_div = (r_quo > NUM_W'(r_color_lim)) ? r_color_lim : r_quo[SAMPLE_BITS-1:0];

    // per-channel results and output register
    logic [SAMPLE_BITS-1:0] r_res [0:2];
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] res_new;
    logic                   res_wr;

    assign res_wr  = i_cmd.rnd | i_cmd.div_store;
    assign res_new = i_cmd.div_store ? res_div : (use_div ? '0 : res_plain);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_samp <= samp_in;
        end
        if (i_cmd.mac_mul) begin
            r_prod  <= ok ? samp_x * wt_x : '0;
            r_wprod <= ok ? wt : '0;
        end
        if (i_cmd.mac_first) begin
            r_acc  <= '0;
            r_wsum <= '0;
        end else if (i_cmd.mac_add) begin
            r_acc  <= r_acc + ACC_W'(r_prod);
            r_wsum <= r_wsum + WSUM_W'(r_wprod);
        end
        if (i_cmd.div_load) begin
            r_quo <= num[NUM_W-1:0];
            r_rem <= '0;
            r_den <= {r_wsum, 1'b0};
        end else if (i_cmd.div_step) begin
            if (rem_sh >= r_den) begin
                r_rem <= rem_sh - r_den;
                r_quo <= {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_quo <= {r_quo[NUM_W-2:0], 1'b0};
            end
        end
        if (i_cmd.load) begin
            r_res[0] <= '0;
            r_res[1] <= '0;
            r_res[2] <= '0;
        end else if (res_wr) begin
            unique case (i_cmd.ch)
                2'd0:    r_res[0] <= res_new;
                2'd1:    r_res[1] <= res_new;
                default: r_res[2] <= res_new;
            endcase
        end
        if (i_cmd.out_load) begin
            o_res_zero  <= r_res[0];
            o_res_one   <= r_res[1];
            o_res_two   <= r_res[2];
            o_frame_end <= frame_end;
        end
    end

    // control state: positions, window, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[c][r] <= '0;
                end
            end
        end else begin
            if (i_cmd.load) begin
                r_win[0][0] <= r_win[1][0];
                r_win[0][1] <= r_win[1][1];
                r_win[0][2] <= r_win[1][2];
                r_win[1][0] <= r_win[2][0];
                r_win[1][1] <= r_win[2][1];
                r_win[1][2] <= r_win[2][2];
                r_win[2][0] <= older_rd;
                r_win[2][1] <= newer_rd;
                r_win[2][2] <= r_samp;
                if (in_col_inc >= w_eff) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + 1'b1;
                end else begin
                    r_in_col <= in_col_inc;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
                if (frame_end) begin
                    r_in_col  <= '0;
                    r_in_row  <= '0;
                    r_out_col <= '0;
                    r_out_row <= '0;
                    for (int c = 0; c < 3; c++) begin
                        for (int r = 0; r < 3; r++) begin
                            r_win[c][r] <= '0;
                        end
                    end
                end else if (out_col_inc >= w_eff) begin
                    r_out_col <= '0;
                    r_out_row <= out_row_inc;
                end else begin
                    r_out_col <= out_col_inc;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;

    always_comb begin
        o_sts.drop     = !received && i_kind;
        o_sts.emit     = emit;
        o_sts.use_div  = use_div;
        o_sts.num_neg  = num[ACC_W];
        o_sts.last_ch  = r_color_mode ? (i_cmd.ch == 2'd2) : (i_cmd.ch == 2'd0);
        o_sts.out_free = !r_out_valid || i_ready;
    end

endmodule

>>> src/conv3x3_border_normalized_unit.sv
// Top level of the 3x3 border-normalized convolution unit.
// Usage: pixels enter in raster order on the input channel (i_valid/o_ready),
// one request per pixel; kind=1 requests are drain ticks that flush the last
// row of results once the whole frame has been received. Results leave on
// the output channel (o_valid/i_ready); o_frame_end marks the last pixel.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data);
// the user writes it only while the unit is idle; the unit does not enforce it.
//
// Flow: one request is worked on at a time. A captured request that yields
// no result passes through a row-store read, then window shift and write-back.
// A request that yields a result adds, per channel (one in gray, three in
// RGB), a sweep of the single shared multiplier over the nine taps, a
// rounding step and, when normalizing, the steps of the bit-serial divider,
// then a handoff of the result to the output register.
// Results lag the input by one row plus one pixel.
// Reset: synchronous, clears counters, tap window and configuration to their
// defaults; row stores are not cleared; unwritten entries never reach a result.
// Stall: a result waits in the output register; the unit takes the next
// request meanwhile and holds in its final step only if a second result is
// ready before the first has been taken.
module conv3x3_border_normalized_unit
    import cnv_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_kind,
    input  logic [SAMPLE_BITS-1:0] i_chan_zero,
    input  logic [SAMPLE_BITS-1:0] i_chan_one,
    input  logic [SAMPLE_BITS-1:0] i_chan_two,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [SAMPLE_BITS-1:0] o_res_zero,
    output logic [SAMPLE_BITS-1:0] o_res_one,
    output logic [SAMPLE_BITS-1:0] o_res_two,
    output logic                   o_frame_end,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    cnv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    cnv_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_kind      (i_kind),
        .i_chan_zero (i_chan_zero),
        .i_chan_one  (i_chan_one),
        .i_chan_two  (i_chan_two),
        .i_ready     (i_ready),
        .o_valid     (o_valid),
        .o_res_zero  (o_res_zero),
        .o_res_one   (o_res_one),
        .o_res_two   (o_res_two),
        .o_frame_end (o_frame_end),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

endmodule
